/* sv/date_time_field_stepper_assert.svh */
// assertion macros for the date and time field stepper
// expects clk and arst_n in the scope of the module that uses them
`ifndef DATE_TIME_FIELD_STEPPER_ASSERT_SVH
`define DATE_TIME_FIELD_STEPPER_ASSERT_SVH

`ifndef ASSERT_OFF
`define DTFS_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define DTFS_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define DTFS_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define DTFS_ASSERT(name, prop, msg)
`define DTFS_ASSERT_IMP(name, ante, cons, msg)
`define DTFS_ASSERT_NEXT(name, ante, cons, msg)
`endif

`endif

/* sv/dtfs_pkg.sv */
// types, codes and calendar helpers for the date and time field stepper
// no dependencies
package dtfs_pkg;

	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_INC  = 2'd1,
		OP_DEC  = 2'd2,
		OP_NOP  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		FS_YEAR   = 3'd0,
		FS_MONTH  = 3'd1,
		FS_DAY    = 3'd2,
		FS_HOUR   = 3'd3,
		FS_MINUTE = 3'd4,
		FS_SECOND = 3'd5,
		FS_AMPM   = 3'd6,
		FS_NONE   = 3'd7
	} field_sel_t;

	// dirty mask bit positions, same numbering as the field select codes
	localparam int BIT_YEAR   = 0;
	localparam int BIT_MONTH  = 1;
	localparam int BIT_DAY    = 2;
	localparam int BIT_HOUR   = 3;
	localparam int BIT_MINUTE = 4;
	localparam int BIT_SECOND = 5;
	localparam int BIT_AMPM   = 6;
	localparam int NUM_FIELDS = 7;

	localparam logic [11:0] YEAR_BASE = 12'd2000;
	localparam logic [11:0] YEAR_LAST = 12'd2099;
	localparam logic [6:0]  YOFF_MAX  = 7'd99;
	localparam logic [3:0]  MONTH_MAX = 4'd12;
	localparam logic [4:0]  HOUR_MAX  = 5'd23;
	localparam logic [4:0]  HALF_DAY  = 5'd12;
	localparam logic [5:0]  MS_MAX    = 6'd59;
	localparam logic [4:0]  FEB_DAYS  = 5'd28;

	typedef struct packed {
		logic [5:0] second;
		logic [5:0] minute;
		logic [4:0] hour;
		logic [4:0] day;
		logic [3:0] month;
		logic [6:0] yoff;
	} fields_t;

	typedef struct packed {
		logic [5:0]  second;
		logic [5:0]  minute;
		logic [4:0]  hour;
		logic [4:0]  day;
		logic [3:0]  month;
		logic [11:0] year;
	} load_t;

	// every fourth year is a leap year, which holds for 2000..2099
	function automatic logic [4:0] month_days(logic [3:0] month, logic [6:0] yoff);
		logic [4:0] d;
		if (month == 4'd2)
			d = (yoff[1:0] == 2'b00) ? FEB_DAYS + 5'd1 : FEB_DAYS;
		else if (month == 4'd4 || month == 4'd6 || month == 4'd9 || month == 4'd11)
			d = 5'd30;
		else
			d = 5'd31;
		return d;
	endfunction

endpackage

/* sv/date_time_field_stepper.sv */
// date and time field stepper, top level and only module
// depends on dtfs_pkg and date_time_field_stepper_assert.svh
//
// Holds a date and time for the years 2000 to 2099 and takes one command
// transaction per clock while s_tready is high: a load that writes all
// fields (each saturated into its range, the day clamped to the month) or a
// one-step increment or decrement of the field named in tuser, each field
// wrapping in its own range. Year and month changes clamp the day to the
// new month's length; February has 29 days in every year divisible by four.
// The am/pm field moves the hour by twelve. Every command gives exactly one
// result transaction carrying all fields, the 12-hour display hour, the pm
// flag and a mask of the fields that changed; for loads the mask compares
// against the previous load (the first load after reset flags every field).
// Throughput is one transaction per clock while m_tready is high. The
// command is captured in an input register, the next state and the result
// are formed by a single shallow stage of compare/add/select logic and land
// together in the state and output registers. s_tready drops only when both
// the input and output registers hold data and m_tready is low.
module date_time_field_stepper
	import dtfs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// load_year[11:0], load_month[15:12], load_day[20:16], load_hour[25:21],
	// load_minute[31:26], load_second[37:32], zero pad[39:38]
	input  logic [39:0] s_tdata,
	// opcode[1:0], field_select[4:2]
	input  logic [4:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// year_out[11:0], month_out[15:12], day_out[20:16], hour_out[25:21],
	// minute_out[31:26], second_out[37:32], display_hour[41:38], is_pm[42],
	// dirty_mask[49:43], changed[50], zero pad[55:51]
	output logic [55:0] m_tdata
);

	`include "date_time_field_stepper_assert.svh"

	// input register
	logic       vld_s1;
	op_t        op_s1;
	field_sel_t sel_s1;
	load_t      ld_s1;

	// current state
	fields_t    cur_q;
	fields_t    prev_q;
	logic       loaded_q;

	// output register
	logic        out_vld_q;
	logic [55:0] out_data_q;

	logic out_free;
	logic advance;

	assign out_free = !out_vld_q || m_tready;
	assign advance  = vld_s1 && out_free;
	assign s_tready = !vld_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1  <= op_t'(s_tuser[1:0]);
			sel_s1 <= field_sel_t'(s_tuser[4:2]);
			ld_s1  <= load_t'(s_tdata[37:0]);
		end
	end

	// saturate the load values into range
	logic [11:0] ly_diff;
	fields_t     ld_sat;
	logic [4:0]  ld_dim;

	assign ly_diff = ld_s1.year - YEAR_BASE;

	always_comb begin
		if (ld_s1.year < YEAR_BASE)
			ld_sat.yoff = 7'd0;
		else if (ld_s1.year > YEAR_LAST)
			ld_sat.yoff = YOFF_MAX;
		else
			ld_sat.yoff = ly_diff[6:0];
		if (ld_s1.month == 4'd0)
			ld_sat.month = 4'd1;
		else if (ld_s1.month > MONTH_MAX)
			ld_sat.month = MONTH_MAX;
		else
			ld_sat.month = ld_s1.month;
		ld_dim = month_days(ld_sat.month, ld_sat.yoff);
		if (ld_s1.day == 5'd0)
			ld_sat.day = 5'd1;
		else if (ld_s1.day > ld_dim)
			ld_sat.day = ld_dim;
		else
			ld_sat.day = ld_s1.day;
		ld_sat.hour   = (ld_s1.hour > HOUR_MAX) ? HOUR_MAX : ld_s1.hour;
		ld_sat.minute = (ld_s1.minute > MS_MAX) ? MS_MAX : ld_s1.minute;
		ld_sat.second = (ld_s1.second > MS_MAX) ? MS_MAX : ld_s1.second;
	end

	// next state and dirty mask
	fields_t               nxt;
	logic [NUM_FIELDS-1:0] mask;
	logic                  up;
	logic [4:0]            dim_cur;
	logic [4:0]            dim_new;
	logic                  cur_pm;

	assign up      = (op_s1 == OP_INC);
	assign dim_cur = month_days(cur_q.month, cur_q.yoff);
	assign cur_pm  = (cur_q.hour >= HALF_DAY);

	always_comb begin
		nxt     = cur_q;
		mask    = '0;
		dim_new = dim_cur;
		unique case (op_s1)
			OP_LOAD: begin
				nxt = ld_sat;
				if (!loaded_q) begin
					mask = '1;
				end else begin
					mask[BIT_YEAR]   = (prev_q.yoff != ld_sat.yoff);
					mask[BIT_MONTH]  = (prev_q.month != ld_sat.month);
					mask[BIT_DAY]    = (prev_q.day != ld_sat.day);
					mask[BIT_HOUR]   = (prev_q.hour != ld_sat.hour);
					mask[BIT_AMPM]   = (prev_q.hour != ld_sat.hour) &&
						((prev_q.hour >= HALF_DAY) != (ld_sat.hour >= HALF_DAY));
					mask[BIT_MINUTE] = (prev_q.minute != ld_sat.minute);
					mask[BIT_SECOND] = (prev_q.second != ld_sat.second);
				end
			end
			OP_INC, OP_DEC: begin
				unique case (sel_s1)
					FS_YEAR: begin
						if (up)
							nxt.yoff = (cur_q.yoff >= YOFF_MAX) ? 7'd0 : cur_q.yoff + 7'd1;
						else
							nxt.yoff = (cur_q.yoff == 7'd0) ? YOFF_MAX : cur_q.yoff - 7'd1;
						mask[BIT_YEAR] = 1'b1;
						dim_new = month_days(cur_q.month, nxt.yoff);
						if (cur_q.day > dim_new) begin
							nxt.day       = dim_new;
							mask[BIT_DAY] = 1'b1;
						end
					end
					FS_MONTH: begin
						if (up)
							nxt.month = (cur_q.month >= MONTH_MAX) ? 4'd1 : cur_q.month + 4'd1;
						else
							nxt.month = (cur_q.month <= 4'd1) ? MONTH_MAX : cur_q.month - 4'd1;
						mask[BIT_MONTH] = 1'b1;
						dim_new = month_days(nxt.month, cur_q.yoff);
						if (cur_q.day > dim_new) begin
							nxt.day       = dim_new;
							mask[BIT_DAY] = 1'b1;
						end
					end
					FS_DAY: begin
						if (up)
							nxt.day = (cur_q.day >= dim_cur) ? 5'd1 : cur_q.day + 5'd1;
						else
							nxt.day = (cur_q.day <= 5'd1) ? dim_cur : cur_q.day - 5'd1;
						mask[BIT_DAY] = 1'b1;
					end
					FS_HOUR: begin
						if (up)
							nxt.hour = (cur_q.hour >= HOUR_MAX) ? 5'd0 : cur_q.hour + 5'd1;
						else
							nxt.hour = (cur_q.hour == 5'd0) ? HOUR_MAX : cur_q.hour - 5'd1;
						mask[BIT_HOUR] = 1'b1;
						mask[BIT_AMPM] = (cur_pm != (nxt.hour >= HALF_DAY));
					end
					FS_MINUTE: begin
						if (up)
							nxt.minute = (cur_q.minute >= MS_MAX) ? 6'd0 : cur_q.minute + 6'd1;
						else
							nxt.minute = (cur_q.minute == 6'd0) ? MS_MAX : cur_q.minute - 6'd1;
						mask[BIT_MINUTE] = 1'b1;
					end
					FS_SECOND: begin
						if (up)
							nxt.second = (cur_q.second >= MS_MAX) ? 6'd0 : cur_q.second + 6'd1;
						else
							nxt.second = (cur_q.second == 6'd0) ? MS_MAX : cur_q.second - 6'd1;
						mask[BIT_SECOND] = 1'b1;
					end
					FS_AMPM: begin
						// flip half of the day, no other field touched
						nxt.hour       = cur_pm ? cur_q.hour - HALF_DAY : cur_q.hour + HALF_DAY;
						mask[BIT_AMPM] = 1'b1;
					end
					FS_NONE: begin
					end
					default: begin
					end
				endcase
			end
			OP_NOP: begin
			end
			default: begin
			end
		endcase
	end

	// result formatting
	logic [3:0]  disp_hour;
	logic        nxt_pm;
	logic [11:0] year_full;

	assign nxt_pm    = (nxt.hour >= HALF_DAY);
	assign year_full = {5'd0, nxt.yoff} + YEAR_BASE;

	always_comb begin
		if (nxt.hour > HALF_DAY)
			disp_hour = 4'(nxt.hour - HALF_DAY);
		else if (nxt.hour == 5'd0)
			disp_hour = 4'd12;
		else
			disp_hour = nxt.hour[3:0];
	end

	// state registers move together with the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q.yoff   <= 7'd0;
			cur_q.month  <= 4'd1;
			cur_q.day    <= 5'd1;
			cur_q.hour   <= 5'd0;
			cur_q.minute <= 6'd0;
			cur_q.second <= 6'd0;
			loaded_q     <= 1'b0;
			out_vld_q    <= 1'b0;
		end else begin
			if (advance) begin
				cur_q <= nxt;
				if (op_s1 == OP_LOAD)
					loaded_q <= 1'b1;
			end
			if (out_free)
				out_vld_q <= vld_s1;
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (advance) begin
			if (op_s1 == OP_LOAD)
				prev_q <= ld_sat;
			out_data_q <= {5'd0, (mask != '0), mask, nxt_pm, disp_hour,
				nxt.second, nxt.minute, nxt.hour, nxt.day, nxt.month, year_full};
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;

	`DTFS_ASSERT(a_month_range, cur_q.month >= 4'd1 && cur_q.month <= MONTH_MAX, "month out of range")
	`DTFS_ASSERT(a_day_range, cur_q.day >= 5'd1 && cur_q.day <= dim_cur, "day beyond month length")
	`DTFS_ASSERT(a_time_range, cur_q.yoff <= YOFF_MAX && cur_q.hour <= HOUR_MAX && cur_q.minute <= MS_MAX && cur_q.second <= MS_MAX, "time field out of range")
	`DTFS_ASSERT_IMP(a_changed_flag, out_vld_q, out_data_q[50] == (out_data_q[49:43] != 7'd0), "changed flag disagrees with mask")
	`DTFS_ASSERT_NEXT(a_state_holds_on_stall, out_vld_q && !m_tready, cur_q == $past(cur_q), "state moved while result stalled")

endmodule

/* bench/tb_top.sv */
// testbench for date_time_field_stepper: directed and random command streams,
// checked result by result against a calendar predictor kept in this file
// depends on dtfs_pkg and the date_time_field_stepper rtl
`timescale 1ns / 1ps

module tb_top
	import dtfs_pkg::*;
();

	// receiver behavior between hold-offs
	localparam int RX_OPEN    = 0;
	localparam int RX_RANDOM  = 1;
	localparam int RX_PATTERN = 2;

	// one command as the sender sees it
	typedef struct {
		op_t        op;
		field_sel_t sel;
		load_t      ld;
	} dt_cmd_t;

	// one result transaction, packed in m_tdata order (lowest field last here)
	typedef struct packed {
		logic        changed;
		logic [6:0]  dirty;
		logic        pm;
		logic [3:0]  dh;
		logic [5:0]  second;
		logic [5:0]  minute;
		logic [4:0]  hour;
		logic [4:0]  day;
		logic [3:0]  month;
		logic [11:0] year;
	} stamp_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic [4:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;

	// predicted calendar state, widths as in the block
	logic [6:0] cal_yoff;
	logic [3:0] cal_month;
	logic [4:0] cal_day;
	logic [4:0] cal_hour;
	logic [5:0] cal_minute;
	logic [5:0] cal_second;
	fields_t    last_loaded;
	bit         seen_load;

	stamp_t pending_stamps[$];
	int     mismatch_count;

	// sender and receiver pacing knobs, changed by the tests
	int     gap_max;
	int     burst_max;
	int     burst_left;
	int     rx_mode;
	int     hold_cycles;
	int     hold_seq;
	load_t  last_ld;

	// receiver bookkeeping, owned by the receiver process
	int     hold_seen = 0;
	int     hold_left = 0;
	int     rx_tick = 0;

	date_time_field_stepper uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// hard stop in case a handshake never completes
	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

	// ------------------------------------------------------------------
	// calendar predictor
	// ------------------------------------------------------------------

	// every fourth year is a leap year across 2000..2099
	function automatic logic [4:0] days_in(logic [3:0] m, logic [6:0] yoff);
		if (m == 4'd2)
			return (yoff % 7'd4 == 7'd0) ? FEB_DAYS + 5'd1 : FEB_DAYS;
		if (m == 4'd4 || m == 4'd6 || m == 4'd9 || m == 4'd11)
			return 5'd30;
		return 5'd31;
	endfunction

	function automatic int unsigned wrap_step(int unsigned v, int unsigned lo,
			int unsigned hi, bit up);
		if (up)
			return (v >= hi) ? lo : v + 1;
		return (v <= lo) ? hi : v - 1;
	endfunction

	// pull the day back to the month's last day after a year or month move
	function automatic bit trim_day();
		logic [4:0] dim;
		dim = days_in(cal_month, cal_yoff);
		if (cal_day > dim) begin
			cal_day = dim;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// apply one command to the predicted state and form the result it gives
	function automatic stamp_t step_calendar(dt_cmd_t c);
		stamp_t      r;
		logic [6:0]  mask;
		logic [11:0] y;
		logic [6:0]  yo;
		logic [3:0]  mo;
		logic [4:0]  d, h, dim;
		logic [5:0]  mi, s;
		bit          up, was_pm;
		mask = '0;
		up = (c.op == OP_INC);
		case (c.op)
			OP_LOAD: begin
				y = c.ld.year;
				mo = c.ld.month;
				d = c.ld.day;
				h = c.ld.hour;
				mi = c.ld.minute;
				s = c.ld.second;
				// saturate each field into its range, day last
				if (y < YEAR_BASE) y = YEAR_BASE;
				if (y > YEAR_LAST) y = YEAR_LAST;
				yo = 7'(y - YEAR_BASE);
				if (mo < 4'd1) mo = 4'd1;
				if (mo > MONTH_MAX) mo = MONTH_MAX;
				if (h > HOUR_MAX) h = HOUR_MAX;
				if (mi > MS_MAX) mi = MS_MAX;
				if (s > MS_MAX) s = MS_MAX;
				dim = days_in(mo, yo);
				if (d < 5'd1) d = 5'd1;
				if (d > dim) d = dim;
				// dirty bits compare against the previous load, not the live value
				if (!seen_load) begin
					mask = '1;
				end else begin
					mask[BIT_YEAR] = (last_loaded.yoff != yo);
					mask[BIT_MONTH] = (last_loaded.month != mo);
					mask[BIT_DAY] = (last_loaded.day != d);
					if (last_loaded.hour != h) begin
						mask[BIT_HOUR] = 1'b1;
						mask[BIT_AMPM] = (last_loaded.hour >= HALF_DAY) != (h >= HALF_DAY);
					end
					mask[BIT_MINUTE] = (last_loaded.minute != mi);
					mask[BIT_SECOND] = (last_loaded.second != s);
				end
				cal_yoff = yo;
				cal_month = mo;
				cal_day = d;
				cal_hour = h;
				cal_minute = mi;
				cal_second = s;
				last_loaded.yoff = cal_yoff;
				last_loaded.month = cal_month;
				last_loaded.day = cal_day;
				last_loaded.hour = cal_hour;
				last_loaded.minute = cal_minute;
				last_loaded.second = cal_second;
				seen_load = 1'b1;
			end
			OP_INC, OP_DEC: begin
				case (c.sel)
					FS_YEAR: begin
						cal_yoff = 7'(wrap_step(32'(cal_yoff), 0, 32'(YOFF_MAX), up));
						mask[BIT_YEAR] = 1'b1;
						mask[BIT_DAY] = trim_day();
					end
					FS_MONTH: begin
						cal_month = 4'(wrap_step(32'(cal_month), 1, 32'(MONTH_MAX), up));
						mask[BIT_MONTH] = 1'b1;
						mask[BIT_DAY] = trim_day();
					end
					FS_DAY: begin
						cal_day = 5'(wrap_step(32'(cal_day), 1,
							32'(days_in(cal_month, cal_yoff)), up));
						mask[BIT_DAY] = 1'b1;
					end
					FS_HOUR: begin
						was_pm = (cal_hour >= HALF_DAY);
						cal_hour = 5'(wrap_step(32'(cal_hour), 0, 32'(HOUR_MAX), up));
						mask[BIT_HOUR] = 1'b1;
						mask[BIT_AMPM] = was_pm != (cal_hour >= HALF_DAY);
					end
					FS_MINUTE: begin
						cal_minute = 6'(wrap_step(32'(cal_minute), 0, 32'(MS_MAX), up));
						mask[BIT_MINUTE] = 1'b1;
					end
					FS_SECOND: begin
						cal_second = 6'(wrap_step(32'(cal_second), 0, 32'(MS_MAX), up));
						mask[BIT_SECOND] = 1'b1;
					end
					FS_AMPM: begin
						// same direction either way: flip to the other half of the day
						cal_hour = (cal_hour >= HALF_DAY) ? cal_hour - HALF_DAY
							: cal_hour + HALF_DAY;
						mask[BIT_AMPM] = 1'b1;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
		r.year = YEAR_BASE + {5'd0, cal_yoff};
		r.month = cal_month;
		r.day = cal_day;
		r.hour = cal_hour;
		r.minute = cal_minute;
		r.second = cal_second;
		// 12-hour display: midnight shows 12, afternoon hours fold down
		if (cal_hour > HALF_DAY)
			r.dh = 4'(cal_hour - HALF_DAY);
		else if (cal_hour == 5'd0)
			r.dh = 4'd12;
		else
			r.dh = cal_hour[3:0];
		r.pm = (cal_hour >= HALF_DAY);
		r.dirty = mask;
		r.changed = |mask;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// result checking
	// ------------------------------------------------------------------

	function automatic void flag_error(string msg);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got)
			flag_error($sformatf("%s expected %0d, got %0d", name, want, got));
	endfunction

	// every accepted result is matched against the oldest prediction
	always @(posedge clk) begin : result_checker
		stamp_t want;
		stamp_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[50:0];
			if (pending_stamps.size() == 0) begin
				flag_error($sformatf("result with nothing pending, data %h", m_tdata));
			end else begin
				want = pending_stamps.pop_front();
				check_field("year", 32'(want.year), 32'(got.year));
				check_field("month", 32'(want.month), 32'(got.month));
				check_field("day", 32'(want.day), 32'(got.day));
				check_field("hour", 32'(want.hour), 32'(got.hour));
				check_field("minute", 32'(want.minute), 32'(got.minute));
				check_field("second", 32'(want.second), 32'(got.second));
				check_field("display_hour", 32'(want.dh), 32'(got.dh));
				check_field("is_pm", 32'(want.pm), 32'(got.pm));
				check_field("dirty_mask", 32'(want.dirty), 32'(got.dirty));
				check_field("changed", 32'(want.changed), 32'(got.changed));
			end
		end
	end

	// receiver: a long hold-off when asked, otherwise open, random or patterned
	always @(posedge clk) begin : receiver_pacing
		rx_tick++;
		if (hold_seq != hold_seen) begin
			hold_seen = hold_seq;
			hold_left = hold_cycles;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			case (rx_mode)
				RX_RANDOM:  m_tready <= ($urandom_range(0, 3) != 0);
				RX_PATTERN: m_tready <= ((rx_tick % 7) < 4);
				default:    m_tready <= 1'b1;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// sender
	// ------------------------------------------------------------------

	// drive one command and hold it until the block takes the transaction
	task automatic send_cmd(input dt_cmd_t c);
		s_tdata <= {2'b00, c.ld};
		s_tuser <= {c.sel, c.op};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		pending_stamps.push_back(step_calendar(c));
	endtask

	task automatic idle_sender(input int cycles);
		s_tvalid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// bursts of back-to-back transactions separated by random gaps
	task automatic issue(input dt_cmd_t c);
		if (gap_max > 0 && burst_left == 0) begin
			idle_sender($urandom_range(1, gap_max));
			burst_left = $urandom_range(1, burst_max);
		end
		if (burst_left > 0)
			burst_left--;
		send_cmd(c);
	endtask

	// stop offering and let every predicted result come back
	task automatic wait_drained();
		int guard;
		guard = 0;
		s_tvalid <= 1'b0;
		while (pending_stamps.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		if (pending_stamps.size() != 0) begin
			flag_error($sformatf("%0d results never arrived", pending_stamps.size()));
			pending_stamps.delete();
		end
		// then let the bus sit idle before returning
		repeat (4) @(posedge clk);
	endtask

	function automatic dt_cmd_t mk_load(int y, int mo, int d, int h, int mi, int s);
		dt_cmd_t c;
		c.op = OP_LOAD;
		c.sel = FS_NONE;
		c.ld.year = 12'(y);
		c.ld.month = 4'(mo);
		c.ld.day = 5'(d);
		c.ld.hour = 5'(h);
		c.ld.minute = 6'(mi);
		c.ld.second = 6'(s);
		return c;
	endfunction

	function automatic dt_cmd_t mk_step(op_t op, field_sel_t sel);
		dt_cmd_t c;
		c.op = op;
		c.sel = sel;
		c.ld = '0;
		return c;
	endfunction

	// random load values: raw bits now and then, otherwise in range with days
	// near month end and fields often repeated from the last load
	function automatic load_t pick_load();
		load_t ld;
		if ($urandom_range(0, 4) == 0) begin
			ld.year = 12'($urandom);
			ld.month = 4'($urandom);
			ld.day = 5'($urandom);
			ld.hour = 5'($urandom);
			ld.minute = 6'($urandom);
			ld.second = 6'($urandom);
		end else begin
			ld.year = $urandom_range(0, 2) == 0 ? last_ld.year
				: 12'(32'(YEAR_BASE) + $urandom_range(0, 99));
			ld.month = $urandom_range(0, 2) == 0 ? last_ld.month
				: 4'($urandom_range(1, 12));
			ld.day = $urandom_range(0, 1) ? 5'($urandom_range(26, 31))
				: 5'($urandom_range(1, 31));
			ld.hour = $urandom_range(0, 2) == 0 ? last_ld.hour
				: 5'($urandom_range(0, 23));
			ld.minute = $urandom_range(0, 2) == 0 ? last_ld.minute
				: 6'($urandom_range(0, 59));
			ld.second = $urandom_range(0, 2) == 0 ? last_ld.second
				: 6'($urandom_range(0, 59));
		end
		last_ld = ld;
		return ld;
	endfunction

	function automatic dt_cmd_t pick_cmd();
		dt_cmd_t c;
		int      roll;
		roll = $urandom_range(0, 99);
		c.sel = field_sel_t'(3'($urandom_range(0, 7)));
		if (roll < 15) begin
			c.op = OP_LOAD;
			c.ld = pick_load();
		end else begin
			// loads fields ride along unused on steps and no-ops
			c.op = (roll < 18) ? OP_NOP : ($urandom_range(0, 1) ? OP_INC : OP_DEC);
			c.ld.year = 12'($urandom);
			c.ld.month = 4'($urandom);
			c.ld.day = 5'($urandom);
			c.ld.hour = 5'($urandom);
			c.ld.minute = 6'($urandom);
			c.ld.second = 6'($urandom);
		end
		return c;
	endfunction

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// first load flags everything, repeats flag nothing, saturation, clamping
	task automatic test_load_extremes();
		gap_max = 0;
		rx_mode = RX_OPEN;
		send_cmd(mk_load(2000, 1, 1, 0, 0, 0));
		send_cmd(mk_load(2000, 1, 1, 0, 0, 0));
		send_cmd(mk_load(12'hfff, 15, 31, 31, 63, 63));
		send_cmd(mk_load(0, 0, 0, 0, 0, 0));
		// leap february: day 31 clamps to 29
		send_cmd(mk_load(2004, 2, 31, 13, 30, 30));
		// into a common year, day clamps to 28
		send_cmd(mk_step(OP_INC, FS_YEAR));
		send_cmd(mk_step(OP_DEC, FS_MONTH));
		send_cmd(mk_step(OP_DEC, FS_MONTH));
		send_cmd(mk_step(OP_INC, FS_MONTH));
		send_cmd(mk_load(2001, 1, 31, 0, 0, 0));
		send_cmd(mk_step(OP_INC, FS_MONTH));
		wait_drained();
	endtask

	// year, day, minute and second wrapped at both ends, hour at the top, am/pm, no field and no-op
	task automatic test_field_wraps();
		rx_mode = RX_PATTERN;
		send_cmd(mk_load(2099, 12, 31, 23, 59, 59));
		send_cmd(mk_step(OP_INC, FS_YEAR));
		send_cmd(mk_step(OP_INC, FS_DAY));
		send_cmd(mk_step(OP_INC, FS_HOUR));
		send_cmd(mk_step(OP_INC, FS_MINUTE));
		send_cmd(mk_step(OP_INC, FS_SECOND));
		send_cmd(mk_step(OP_INC, FS_AMPM));
		send_cmd(mk_step(OP_DEC, FS_DAY));
		send_cmd(mk_step(OP_DEC, FS_YEAR));
		send_cmd(mk_step(OP_DEC, FS_HOUR));
		send_cmd(mk_step(OP_DEC, FS_MINUTE));
		send_cmd(mk_step(OP_DEC, FS_SECOND));
		send_cmd(mk_step(OP_INC, FS_NONE));
		send_cmd(mk_step(OP_NOP, FS_HOUR));
		wait_drained();
	endtask

	// receiver holds off long enough that the block fills and stalls its input
	task automatic test_receiver_holdoff();
		gap_max = 0;
		rx_mode = RX_OPEN;
		hold_cycles = 300;
		hold_seq++;
		repeat (40) send_cmd(pick_cmd());
		wait_drained();
	endtask

	// sender goes quiet until the block is empty, then resumes
	task automatic test_drain_pause();
		rx_mode = RX_RANDOM;
		repeat (20) send_cmd(pick_cmd());
		wait_drained();
		repeat (20) send_cmd(pick_cmd());
		wait_drained();
	endtask

	// random mix in chunks, each with its own sender and receiver pacing
	task automatic test_random_mix(input int total);
		dt_cmd_t c;
		int      sent;
		sent = 0;
		while (sent < total) begin
			if (sent % 100 == 0) begin
				rx_mode = $urandom_range(RX_OPEN, RX_PATTERN);
				gap_max = $urandom_range(0, 1) ? $urandom_range(1, 6) : 0;
				burst_max = $urandom_range(1, 12);
				burst_left = 0;
			end
			c = pick_cmd();
			issue(c);
			sent++;
		end
		wait_drained();
	endtask

	initial begin : main_seq
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= '0;
		cal_yoff = '0;
		cal_month = 4'd1;
		cal_day = 5'd1;
		cal_hour = '0;
		cal_minute = '0;
		cal_second = '0;
		last_loaded = '0;
		seen_load = 1'b0;
		mismatch_count = 0;
		gap_max = 0;
		burst_max = 1;
		burst_left = 0;
		rx_mode = RX_OPEN;
		hold_cycles = 0;
		hold_seq = 0;
		last_ld = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_load_extremes();
		test_field_wraps();
		test_receiver_holdoff();
		test_drain_pause();
		test_random_mix(900);

		rx_mode = RX_OPEN;
		wait_drained();
		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
